@@ rtl/lpwf_pkg.sv @@
// Shared constants and character helpers for the longest palindrome word finder.
// No dependencies.
package lpwf_pkg;

  localparam int BYTE_W = 8;
  localparam int CHAR_W = 7;
  localparam int LEN_W  = 6;

  // item kinds carried in tuser on the input side
  localparam logic MODE_TEXT = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic [BYTE_W-1:0] ASCII_0     = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_9     = 8'h39;
  localparam logic [BYTE_W-1:0] ASCII_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UP_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] ASCII_LO_A  = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LO_Z  = 8'h7A;
  localparam logic [BYTE_W-1:0] ASCII_CASE  = 8'h20;

  function automatic logic is_upper(input logic [BYTE_W-1:0] b);
    return (b >= ASCII_UP_A) && (b <= ASCII_UP_Z);
  endfunction

  function automatic logic is_word_char(input logic [BYTE_W-1:0] b);
    return ((b >= ASCII_0) && (b <= ASCII_9)) || is_upper(b) ||
           ((b >= ASCII_LO_A) && (b <= ASCII_LO_Z));
  endfunction

  function automatic logic [CHAR_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = is_upper(b) ? (b + ASCII_CASE) : b;
    return v[CHAR_W-1:0];
  endfunction

endpackage

@@ rtl/longest_palindrome_word_finder.sv @@
// Longest palindrome word finder: byte stream in, best palindrome word out per text.
// Depends on lpwf_pkg.
//
// Text bytes (in_tuser = 0) are taken one per cycle while a word is being built.
// A separator or end-of-text item that closes a word of two or more characters which
// could beat the current best starts a compare sequencer: one comparator walks the
// word from both ends, one character pair at a time through the two read ports of
// the word memory, and no input is taken meanwhile. Word and best word live
// in two banks of one memory; a winning word is kept by swapping banks, not copied.
// The report after end of text reads the best bank back one character per result,
// or gives one result with none_found set. A result waiting in the output register
// does not stop new input items from being taken.
module longest_palindrome_word_finder
  import lpwf_pkg::*;
#(
  parameter int MAX_WORD = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] out_char, [12:7] out_length, [15:13] zero
  output logic        out_tuser,  // [0] none_found
  output logic        out_tlast   // last
);

  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CK_RD,
    S_CK_CMP,
    S_RP_RD,
    S_RP_OUT,
    S_RP_NONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  word_len_r, word_len_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              sel_r, sel_nxt;      // bank holding the best word
  logic              rpt_r, rpt_nxt;      // report follows the current close
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_none_r, out_none_nxt;
  logic              out_last_r, out_last_nxt;

  // two-bank character memory, one write port and two registered read ports
  logic [CHAR_W-1:0] mem_r [2][MAX_WORD];
  logic              mem_we;
  logic [AW-1:0]     mem_widx;
  logic [CHAR_W-1:0] mem_wdata;
  logic              rd_bank;
  logic [AW-1:0]     rd_a_idx, rd_b_idx;
  logic [CHAR_W-1:0] rd_a_r, rd_b_r;

  logic              out_free;
  logic              in_fire;
  logic              close_req;
  logic              report;
  logic [LEN_W-1:0]  best_after;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_len_r, out_char_r};
  assign out_tuser  = out_none_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    word_len_nxt  = word_len_r;
    best_len_nxt  = best_len_r;
    ovf_nxt       = ovf_r;
    sel_nxt       = sel_r;
    rpt_nxt       = rpt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_none_nxt  = out_none_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_widx      = word_len_r[AW-1:0];
    mem_wdata     = to_lower(in_tdata);
    rd_bank       = !sel_r;
    rd_a_idx      = lo_r;
    rd_b_idx      = hi_r;
    close_req     = (in_tuser == MODE_END) || !is_word_char(in_tdata);
    report        = rpt_r;
    best_after    = best_len_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!close_req) begin
            if (word_len_r < MAX_LEN) begin
              mem_we       = 1'b1;
              word_len_nxt = word_len_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            report  = (in_tuser == MODE_END);
            rpt_nxt = report;
            lo_nxt  = '0;
            hi_nxt  = AW'(word_len_r - 1'b1);
            if (!ovf_r && (word_len_r > best_len_r) && (word_len_r != LEN_W'(1))) begin
              state_nxt = S_CK_RD;
            end else begin
              // a single character is a palindrome; anything else cannot win
              if (!ovf_r && (word_len_r > best_len_r)) begin
                sel_nxt    = !sel_r;
                best_after = word_len_r;
              end
              best_len_nxt = best_after;
              word_len_nxt = '0;
              ovf_nxt      = 1'b0;
              k_nxt        = '0;
              if (report) begin
                state_nxt = (best_after == '0) ? S_RP_NONE : S_RP_RD;
              end
            end
          end
        end
      end
      S_CK_RD: begin
        state_nxt = S_CK_CMP;
      end
      S_CK_CMP: begin
        if ((rd_a_r == rd_b_r) && (({1'b0, lo_r} + 2'd2) < {1'b0, hi_r})) begin
          lo_nxt    = lo_r + 1'b1;
          hi_nxt    = hi_r - 1'b1;
          state_nxt = S_CK_RD;
        end else begin
          if (rd_a_r == rd_b_r) begin
            sel_nxt    = !sel_r;
            best_after = word_len_r;
          end
          best_len_nxt = best_after;
          word_len_nxt = '0;
          ovf_nxt      = 1'b0;
          k_nxt        = '0;
          if (rpt_r) begin
            state_nxt = (best_after == '0) ? S_RP_NONE : S_RP_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RP_RD: begin
        rd_bank   = sel_r;
        rd_a_idx  = k_r;
        state_nxt = S_RP_OUT;
      end
      S_RP_OUT: begin
        // hold the read address so the character survives an output stall
        rd_bank  = sel_r;
        rd_a_idx = k_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rd_a_r;
          out_len_nxt   = best_len_r;
          out_none_nxt  = 1'b0;
          out_last_nxt  = ((LEN_W'(k_r) + 1'b1) == best_len_r);
          if ((LEN_W'(k_r) + 1'b1) == best_len_r) begin
            best_len_nxt = '0;
            rpt_nxt      = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_RP_RD;
          end
        end
      end
      S_RP_NONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_len_nxt   = '0;
          out_none_nxt  = 1'b1;
          out_last_nxt  = 1'b1;
          rpt_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[!sel_r][mem_widx] <= mem_wdata;
    end
    rd_a_r <= mem_r[rd_bank][rd_a_idx];
    rd_b_r <= mem_r[rd_bank][rd_b_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      word_len_r  <= '0;
      best_len_r  <= '0;
      ovf_r       <= 1'b0;
      sel_r       <= 1'b0;
      rpt_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_len_r  <= word_len_nxt;
      best_len_r  <= best_len_nxt;
      ovf_r       <= ovf_nxt;
      sel_r       <= sel_nxt;
      rpt_r       <= rpt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    k_r        <= k_nxt;
    out_char_r <= out_char_nxt;
    out_len_r  <= out_len_nxt;
    out_none_r <= out_none_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ tb/longest_palindrome_word_finder_tb.sv @@
// Self-checking testbench for longest_palindrome_word_finder: streams texts byte by byte
// and checks every reported character against a behavioral tracker of the best word.
// Depends on lpwf_pkg and the RTL top level.
`timescale 1ns / 1ps

module longest_palindrome_word_finder_tb;
  import lpwf_pkg::*;

  localparam int MAX_WORD       = 32;
  localparam int RANDOM_ITEMS   = 170;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 64;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              none;
    logic              last;
  } report_t;

  // Tracks the open word and the best palindrome, and queues the report each end of text
  // should produce.
  class longest_word_tracker;
    report_t           report_q[$];
    logic [CHAR_W-1:0] word_chars[MAX_WORD];
    logic [CHAR_W-1:0] best_chars[MAX_WORD];
    int unsigned       word_len;
    int unsigned       best_len;
    bit                word_over;
    int unsigned       mismatches;

    function new();
      word_len   = 0;
      best_len   = 0;
      word_over  = 0;
      mismatches = 0;
    endfunction

    function bit is_alnum(logic [BYTE_W-1:0] b);
      return (b >= ASCII_0 && b <= ASCII_9) || (b >= ASCII_UP_A && b <= ASCII_UP_Z) ||
             (b >= ASCII_LO_A && b <= ASCII_LO_Z);
    endfunction

    function void close_word();
      bit mirrored;
      mirrored = (word_len > 0);
      for (int i = 0; i < word_len / 2; i++)
        if (word_chars[i] != word_chars[word_len - 1 - i]) mirrored = 0;
      if (!word_over && mirrored && word_len > best_len) begin
        for (int i = 0; i < word_len; i++) best_chars[i] = word_chars[i];
        best_len = word_len;
      end
      word_len  = 0;
      word_over = 0;
    endfunction

    function void take_item(logic mode, logic [BYTE_W-1:0] b);
      report_t r;
      logic [BYTE_W-1:0] folded;
      if (mode == MODE_TEXT) begin
        if (is_alnum(b)) begin
          folded = (b >= ASCII_UP_A && b <= ASCII_UP_Z) ? b + ASCII_CASE : b;
          if (word_len < MAX_WORD) begin
            word_chars[word_len] = folded[CHAR_W-1:0];
            word_len++;
          end else begin
            word_over = 1;
          end
        end else if (word_len > 0 || word_over) begin
          close_word();
        end
        return;
      end
      if (word_len > 0 || word_over) close_word();
      if (best_len == 0) begin
        r = '{ch: '0, len: '0, none: 1'b1, last: 1'b1};
        report_q.push_back(r);
      end else begin
        for (int i = 0; i < best_len; i++) begin
          r.ch   = best_chars[i];
          r.len  = best_len[LEN_W-1:0];
          r.none = 1'b0;
          r.last = (i + 1 == best_len);
          report_q.push_back(r);
        end
      end
      best_len = 0;
    endfunction

    function void match_report(logic [15:0] data, logic user, logic lst);
      report_t want;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result char=%h len=%0d none=%b last=%b", $realtime,
                   data[6:0], data[12:7], user, lst);
        return;
      end
      want = report_q.pop_front();
      if (data[6:0] !== want.ch || data[12:7] !== want.len || data[15:13] !== 3'b000 ||
          user !== want.none || lst !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: mismatch exp char=%h len=%0d none=%b last=%b pad=0 | ",
                 $realtime, want.ch, want.len, want.none, want.last);
          $display("got char=%h len=%0d none=%b last=%b pad=%b",
                   data[6:0], data[12:7], user, lst, data[15:13]);
        end
      end
    endfunction

    function int unsigned pending();
      return report_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = MODE_TEXT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  longest_word_tracker tracker;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold_req = 0;
  bit          tx_steady = 1'b1;
  bit          rx_steady = 1'b1;

  longest_palindrome_word_finder #(.MAX_WORD(MAX_WORD)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stop if nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: check accepted results, then pick tready for the next cycle
  initial begin : receiver
    int unsigned hold_left;
    int unsigned r;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        tracker.match_report(out_tdata, out_tuser, out_tlast);
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (rx_steady) begin
        out_tready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_tready = 1'b1;
        end else begin
          out_tready = 1'b0;
          hold_left  = (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  task automatic pause_sender();
    int unsigned r;
    int unsigned gap;
    gap = 0;
    if (!tx_steady) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 30);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // offer one item from a falling edge, hold it until accepted, then maybe idle
  task automatic send_item(input logic mode, input logic [7:0] b);
    in_tuser  = mode;
    in_tdata  = b;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_item(mode, b);
    items_sent++;
    @(negedge clk);
    pause_sender();
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_base();
    int r;
    r = $urandom_range(0, 35);
    return (r < 10) ? ASCII_0 + r[7:0] : ASCII_LO_A + r[7:0] - 8'd10;
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] b);
    if (b >= ASCII_LO_A && b <= ASCII_LO_Z && $urandom_range(0, 1) == 1) return b - ASCII_CASE;
    return b;
  endfunction

  function automatic logic [7:0] pick_separator();
    logic [7:0] edges[11] = '{8'h00, 8'h20, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B,
                              8'h7F, 8'h80, 8'hFF};
    logic [7:0] b;
    if ($urandom_range(0, 2) == 0) return edges[$urandom_range(0, 10)];
    do b = 8'($urandom_range(0, 255));
    while (tracker.is_alnum(b));
    return b;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 16);
    return $urandom_range(28, 34);
  endfunction

  // style: 0 palindrome, 1 arbitrary, 2 one repeated character
  task automatic send_word(input int len, input int style);
    logic [7:0] base[64];
    for (int i = 0; i < len; i++) begin
      if (style == 2) base[i] = (i == 0) ? pick_base() : base[0];
      else if (style == 0 && i >= (len + 1) / 2) base[i] = base[len - 1 - i];
      else base[i] = pick_base();
    end
    for (int i = 0; i < len; i++) send_item(MODE_TEXT, vary_case(base[i]));
  endtask

  task automatic send_random_text();
    int words;
    int r;
    words = $urandom_range(1, 6);
    for (int w = 0; w < words; w++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // noise burst, now and then a stray end of text
        repeat ($urandom_range(1, 5))
          send_item(($urandom_range(0, 15) == 0) ? MODE_END : MODE_TEXT,
                    8'($urandom_range(0, 255)));
      end else begin
        send_word(pick_len(), (r < 64) ? 0 : (r < 90) ? 1 : 2);
      end
      if (w + 1 < words || $urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 2)) send_item(MODE_TEXT, pick_separator());
    end
    send_item(MODE_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int unsigned stop_at;
    tracker = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty text, case folding, high-bit separator, shorter word ignored
    send_item(MODE_END, 8'hFF);
    send_item(MODE_TEXT, "A");
    send_item(MODE_TEXT, "b");
    send_item(MODE_TEXT, "A");
    send_item(MODE_TEXT, 8'h80);
    send_item(MODE_TEXT, "x");
    send_item(MODE_END, 8'h00);
    // equal length keeps the earlier word; end of text closes the open word
    send_item(MODE_TEXT, "0");
    send_item(MODE_TEXT, "9");
    send_item(MODE_TEXT, "0");
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, "9");
    send_item(MODE_TEXT, "0");
    send_item(MODE_TEXT, "9");
    send_item(MODE_END, 8'h5A);
    // separators with no open word, letter range edges
    send_item(MODE_TEXT, " ");
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_TEXT, "a");
    send_item(MODE_TEXT, "Z");
    send_item(MODE_TEXT, "z");
    send_item(MODE_TEXT, "A");
    send_item(MODE_END, 8'h7F);
    // non-palindrome only
    send_item(MODE_TEXT, "a");
    send_item(MODE_TEXT, "b");
    send_item(MODE_END, 8'hAA);
    wait_drained();

    // overlong word never wins; a full-length word does
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    send_word(MAX_WORD + 1, 2);
    send_item(MODE_TEXT, pick_separator());
    send_word(MAX_WORD - 1, 0);
    send_item(MODE_END, 8'($urandom_range(0, 255)));
    send_word(MAX_WORD, 0);
    send_item(MODE_END, 8'($urandom_range(0, 255)));
    send_word(MAX_WORD + 2, 0);
    send_item(MODE_END, 8'($urandom_range(0, 255)));

    // hold the output off while texts keep coming, so the input backs up
    tx_steady   = 1'b1;
    rx_hold_req = 300;
    send_random_text();
    send_random_text();
    send_random_text();
    wait_drained();

    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      send_random_text();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
